// ----- rtl/core/obb_overlap_test_assert.svh -----
// assertion macros for the box overlap test checker
// no dependencies; the including scope provides clk and rst
`ifndef OBB_OVERLAP_TEST_ASSERT_SVH
`define OBB_OVERLAP_TEST_ASSERT_SVH

// implication checked outside reset
`define OBT_AST(lbl, ante, cons) lbl: assert property (@(posedge clk) disable iff (rst) \
  (ante) |-> cons) else $error("obb overlap test: check failed");

// implication checked at every edge, reset included
`define OBT_AST_ANY(lbl, ante, cons) lbl: assert property (@(posedge clk) \
  (ante) |=> cons) else $error("obb overlap test: reset check failed");

`endif

// ----- rtl/core/obt_pkg.sv -----
// shared constants for the box overlap test pipeline
// no dependencies
`timescale 1ns / 1ps
package obt_pkg;

  localparam int OBT_COORD_BITS = 20;
  localparam int OBT_AXIS_BITS  = 16;
  localparam int OBT_LATENCY    = 7;

  // cyclic successor and predecessor of an axis index
  localparam int OBT_NXT [3] = '{1, 2, 0};
  localparam int OBT_PRV [3] = '{2, 0, 1};

endpackage

// ----- rtl/core/obt_front.sv -----
// front stages: field decode, centre difference, rotation and translation dot products
// depends on obt_pkg for parameter defaults
`timescale 1ns / 1ps
module obt_front #(
  parameter int COORD_BITS = obt_pkg::OBT_COORD_BITS,
  parameter int AXIS_BITS  = obt_pkg::OBT_AXIS_BITS,
  localparam int VW = COORD_BITS + 1,
  localparam int TW = VW + AXIS_BITS + 2,
  localparam int RW = 2 * AXIS_BITS + 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [3*COORD_BITS-1:0]      a_extents,
  input  logic [3*COORD_BITS-1:0]      a_centre,
  input  logic [3*AXIS_BITS-1:0]       a_axis_0,
  input  logic [3*AXIS_BITS-1:0]       a_axis_1,
  input  logic [3*AXIS_BITS-1:0]       a_axis_2,
  input  logic [3*COORD_BITS-1:0]      b_extents,
  input  logic [3*COORD_BITS-1:0]      b_centre,
  input  logic [3*AXIS_BITS-1:0]       b_axis_0,
  input  logic [3*AXIS_BITS-1:0]       b_axis_1,
  input  logic [3*AXIS_BITS-1:0]       b_axis_2,
  output logic                         out_valid,
  output logic [COORD_BITS-1:0]        ea [3],
  output logic [COORD_BITS-1:0]        eb [3],
  output logic signed [TW-1:0]         t [3],
  output logic signed [RW-1:0]         r [3][3],
  output logic [RW-1:0]                absr [3][3]
);

  logic [COORD_BITS-1:0]              ea0 [3];
  logic [COORD_BITS-1:0]              eb0 [3];
  logic signed [VW-1:0]               vd0 [3];
  logic signed [AXIS_BITS-1:0]        ax0 [3][3];
  logic signed [AXIS_BITS-1:0]        bx0 [3][3];

  logic                               v1;
  logic [COORD_BITS-1:0]              ea1 [3];
  logic [COORD_BITS-1:0]              eb1 [3];
  logic signed [VW-1:0]               vd1 [3];
  logic signed [AXIS_BITS-1:0]        ax1 [3][3];
  logic signed [AXIS_BITS-1:0]        bx1 [3][3];

  logic                               v2;
  logic [COORD_BITS-1:0]              ea2 [3];
  logic [COORD_BITS-1:0]              eb2 [3];
  logic signed [2*AXIS_BITS-1:0]      prr2 [3][3][3];
  logic signed [VW+AXIS_BITS-1:0]     ptv2 [3][3];

  logic signed [RW-1:0]               rsum [3][3];
  logic signed [TW-1:0]               tsum [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ea0[c] = a_extents[c*COORD_BITS +: COORD_BITS];
      eb0[c] = b_extents[c*COORD_BITS +: COORD_BITS];
      vd0[c] = VW'($signed(b_centre[c*COORD_BITS +: COORD_BITS]))
             - VW'($signed(a_centre[c*COORD_BITS +: COORD_BITS]));
      ax0[0][c] = $signed(a_axis_0[c*AXIS_BITS +: AXIS_BITS]);
      ax0[1][c] = $signed(a_axis_1[c*AXIS_BITS +: AXIS_BITS]);
      ax0[2][c] = $signed(a_axis_2[c*AXIS_BITS +: AXIS_BITS]);
      bx0[0][c] = $signed(b_axis_0[c*AXIS_BITS +: AXIS_BITS]);
      bx0[1][c] = $signed(b_axis_1[c*AXIS_BITS +: AXIS_BITS]);
      bx0[2][c] = $signed(b_axis_2[c*AXIS_BITS +: AXIS_BITS]);
    end
  end

  // stage 1: decoded word
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ea1 <= ea0;
    eb1 <= eb0;
    vd1 <= vd0;
    ax1 <= ax0;
    bx1 <= bx0;
  end

  // stage 2: component products
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    ea2 <= ea1;
    eb2 <= eb1;
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) begin
        ptv2[i][c] <= vd1[c] * ax1[i][c];
        for (int k = 0; k < 3; k++) begin
          prr2[i][k][c] <= ax1[i][c] * bx1[k][c];
        end
      end
    end
  end

  // stage 3: dot product sums
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tsum[i] = TW'(ptv2[i][0]) + TW'(ptv2[i][1]) + TW'(ptv2[i][2]);
      for (int k = 0; k < 3; k++) begin
        rsum[i][k] = RW'(prr2[i][k][0]) + RW'(prr2[i][k][1]) + RW'(prr2[i][k][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    ea <= ea2;
    eb <= eb2;
    t  <= tsum;
    r  <= rsum;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        absr[i][k] <= rsum[i][k][RW-1] ? RW'(-rsum[i][k]) : RW'(rsum[i][k]);
      end
    end
  end

endmodule

// ----- rtl/core/obt_mul.sv -----
// middle stages: radius products, split translation products and radius sums
// depends on obt_pkg for defaults and axis index tables
`timescale 1ns / 1ps
module obt_mul #(
  parameter int COORD_BITS = obt_pkg::OBT_COORD_BITS,
  parameter int AXIS_BITS  = obt_pkg::OBT_AXIS_BITS,
  localparam int VW  = COORD_BITS + 1,
  localparam int TW  = VW + AXIS_BITS + 2,
  localparam int RW  = 2 * AXIS_BITS + 2,
  localparam int PW  = TW + RW,
  localparam int FB  = AXIS_BITS - 2,
  localparam int W   = COORD_BITS + 3 * AXIS_BITS + FB + 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [COORD_BITS-1:0]        ea [3],
  input  logic [COORD_BITS-1:0]        eb [3],
  input  logic signed [TW-1:0]         t [3],
  input  logic signed [RW-1:0]         r [3][3],
  input  logic [RW-1:0]                absr [3][3],
  output logic                         out_valid,
  output logic signed [PW-1:0]         tr [3][3][3],
  output logic [W-1:0]                 la [3],
  output logic [W-1:0]                 ra [3],
  output logic [W-1:0]                 rb [3],
  output logic [W-1:0]                 re [3][3]
);
  import obt_pkg::*;

  localparam int RL  = RW / 2;
  localparam int RH  = RW - RL;
  localparam int PAW = COORD_BITS + RW;

  logic                              v4;
  logic [COORD_BITS-1:0]             ea4 [3];
  logic [COORD_BITS-1:0]             eb4 [3];
  logic [TW-1:0]                     tabs4 [3];
  logic [PAW-1:0]                    pa4 [3][3][3];
  logic [PAW-1:0]                    pb4 [3][3][3];
  logic signed [TW+RL:0]             tlo4 [3][3][3];
  logic signed [TW+RH-1:0]           thi4 [3][3][3];

  // stage 4: products
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ea4 <= ea;
    eb4 <= eb;
    for (int j = 0; j < 3; j++) begin
      tabs4[j] <= t[j][TW-1] ? TW'(-t[j]) : TW'(t[j]);
      for (int m = 0; m < 3; m++) begin
        for (int k = 0; k < 3; k++) begin
          pa4[j][m][k]  <= PAW'(ea[j]) * PAW'(absr[m][k]);
          pb4[j][m][k]  <= PAW'(eb[j]) * PAW'(absr[m][k]);
          tlo4[j][m][k] <= t[j] * $signed({1'b0, r[m][k][RL-1:0]});
          thi4[j][m][k] <= t[j] * $signed(r[m][k][RW-1:RL]);
        end
      end
    end
  end

  // stage 5: recombine and sum radii
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      for (int m = 0; m < 3; m++) begin
        for (int k = 0; k < 3; k++) begin
          tr[j][m][k] <= (PW'(thi4[j][m][k]) <<< RL) + PW'(tlo4[j][m][k]);
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      la[i] <= W'(tabs4[i]) << FB;
      ra[i] <= (W'(ea4[i]) << (2 * FB)) + W'(pb4[0][i][0]) + W'(pb4[1][i][1])
             + W'(pb4[2][i][2]);
      rb[i] <= ((W'(eb4[i]) << (2 * FB)) + W'(pa4[0][0][i]) + W'(pa4[1][1][i])
             + W'(pa4[2][2][i])) << FB;
      for (int k = 0; k < 3; k++) begin
        re[i][k] <= (W'(pa4[OBT_NXT[i]][OBT_PRV[i]][k]) + W'(pa4[OBT_PRV[i]][OBT_NXT[i]][k])
                   + W'(pb4[OBT_NXT[k]][i][OBT_PRV[k]]) + W'(pb4[OBT_PRV[k]][i][OBT_NXT[k]]))
                   << FB;
      end
    end
  end

endmodule

// ----- rtl/core/obt_cmp.sv -----
// back stages: projected distances and the fifteen axis comparisons
// depends on obt_pkg for defaults and axis index tables
`timescale 1ns / 1ps
module obt_cmp #(
  parameter int COORD_BITS = obt_pkg::OBT_COORD_BITS,
  parameter int AXIS_BITS  = obt_pkg::OBT_AXIS_BITS,
  localparam int VW  = COORD_BITS + 1,
  localparam int TW  = VW + AXIS_BITS + 2,
  localparam int RW  = 2 * AXIS_BITS + 2,
  localparam int PW  = TW + RW,
  localparam int FB  = AXIS_BITS - 2,
  localparam int W   = COORD_BITS + 3 * AXIS_BITS + FB + 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic signed [PW-1:0]         tr [3][3][3],
  input  logic [W-1:0]                 la [3],
  input  logic [W-1:0]                 ra [3],
  input  logic [W-1:0]                 rb [3],
  input  logic [W-1:0]                 re [3][3],
  output logic                         done,
  output logic                         overlap
);
  import obt_pkg::*;

  logic signed [W-1:0]  sb [3];
  logic signed [W-1:0]  se [3][3];

  logic                 v6;
  logic [W-1:0]         la6 [3];
  logic [W-1:0]         ra6 [3];
  logic [W-1:0]         lb6 [3];
  logic [W-1:0]         rb6 [3];
  logic [W-1:0]         le6 [3][3];
  logic [W-1:0]         re6 [3][3];
  logic                 sep;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sb[k] = W'(tr[0][0][k]) + W'(tr[1][1][k]) + W'(tr[2][2][k]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        se[i][k] = W'(tr[OBT_PRV[i]][OBT_NXT[i]][k]) - W'(tr[OBT_NXT[i]][OBT_PRV[i]][k]);
      end
    end
  end

  // stage 6: magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    la6 <= la;
    ra6 <= ra;
    rb6 <= rb;
    re6 <= re;
    for (int i = 0; i < 3; i++) begin
      lb6[i] <= sb[i][W-1] ? W'(-sb[i]) : W'(sb[i]);
      for (int k = 0; k < 3; k++) begin
        le6[i][k] <= se[i][k][W-1] ? W'(-se[i][k]) : W'(se[i][k]);
      end
    end
  end

  // stage 7: compare and reduce
  always_comb begin
    sep = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sep = sep | (la6[i] > ra6[i]) | (lb6[i] > rb6[i]);
      for (int k = 0; k < 3; k++) begin
        sep = sep | (le6[i][k] > re6[i][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v6;
    end
  end

  always_ff @(posedge clk) begin
    overlap <= ~sep;
  end

endmodule

// ----- rtl/core/obb_overlap_test.sv -----
// top level of the oriented box overlap test: seven-stage pipeline
// depends on obt_pkg, obt_front, obt_mul and obt_cmp
//
//   port group   direction   handshake
//   box pair     in          start, busy (busy is held low)
//   overlap      out         done strobe, one cycle, no back pressure
//
// one word is taken every cycle; the result strobes when the word leaves the last stage
// the register stages, in order: decode, products, dot sums, radius and
// translation products, recombine, magnitudes, compare
// synchronous reset clears the valid bits of all stages; payload registers are not reset
// nothing stalls: busy never rises and every stage advances every cycle
`timescale 1ns / 1ps
module obb_overlap_test #(
  parameter int COORD_BITS = obt_pkg::OBT_COORD_BITS,
  parameter int AXIS_BITS  = obt_pkg::OBT_AXIS_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [3*COORD_BITS-1:0]      a_extents,
  input  logic [3*COORD_BITS-1:0]      a_centre,
  input  logic [3*AXIS_BITS-1:0]       a_axis_0,
  input  logic [3*AXIS_BITS-1:0]       a_axis_1,
  input  logic [3*AXIS_BITS-1:0]       a_axis_2,
  input  logic [3*COORD_BITS-1:0]      b_extents,
  input  logic [3*COORD_BITS-1:0]      b_centre,
  input  logic [3*AXIS_BITS-1:0]       b_axis_0,
  input  logic [3*AXIS_BITS-1:0]       b_axis_1,
  input  logic [3*AXIS_BITS-1:0]       b_axis_2,
  output logic                         done,
  output logic                         overlap
);

  localparam int VW  = COORD_BITS + 1;
  localparam int TW  = VW + AXIS_BITS + 2;
  localparam int RW  = 2 * AXIS_BITS + 2;
  localparam int PW  = TW + RW;
  localparam int FB  = AXIS_BITS - 2;
  localparam int W   = COORD_BITS + 3 * AXIS_BITS + FB + 8;

  logic                   fv;
  logic [COORD_BITS-1:0]  ea [3];
  logic [COORD_BITS-1:0]  eb [3];
  logic signed [TW-1:0]   t [3];
  logic signed [RW-1:0]   r [3][3];
  logic [RW-1:0]          absr [3][3];

  logic                   mv;
  logic signed [PW-1:0]   tr [3][3][3];
  logic [W-1:0]           la [3];
  logic [W-1:0]           ra [3];
  logic [W-1:0]           rb [3];
  logic [W-1:0]           re [3][3];

  assign busy = 1'b0;

  obt_front #(
    .COORD_BITS(COORD_BITS),
    .AXIS_BITS (AXIS_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .a_extents (a_extents),
    .a_centre  (a_centre),
    .a_axis_0  (a_axis_0),
    .a_axis_1  (a_axis_1),
    .a_axis_2  (a_axis_2),
    .b_extents (b_extents),
    .b_centre  (b_centre),
    .b_axis_0  (b_axis_0),
    .b_axis_1  (b_axis_1),
    .b_axis_2  (b_axis_2),
    .out_valid (fv),
    .ea        (ea),
    .eb        (eb),
    .t         (t),
    .r         (r),
    .absr      (absr)
  );

  obt_mul #(
    .COORD_BITS(COORD_BITS),
    .AXIS_BITS (AXIS_BITS)
  ) u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fv),
    .ea        (ea),
    .eb        (eb),
    .t         (t),
    .r         (r),
    .absr      (absr),
    .out_valid (mv),
    .tr        (tr),
    .la        (la),
    .ra        (ra),
    .rb        (rb),
    .re        (re)
  );

  obt_cmp #(
    .COORD_BITS(COORD_BITS),
    .AXIS_BITS (AXIS_BITS)
  ) u_cmp (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mv),
    .tr       (tr),
    .la       (la),
    .ra       (ra),
    .rb       (rb),
    .re       (re),
    .done     (done),
    .overlap  (overlap)
  );

endmodule

// ----- rtl/core/obt_checker.sv -----
// port-level checks for obb_overlap_test, attached by bind
// depends on obt_pkg and obb_overlap_test_assert.svh
`timescale 1ns / 1ps
`include "obb_overlap_test_assert.svh"
module obt_checker #(
  parameter int LAT = obt_pkg::OBT_LATENCY
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // every taken word is followed by its done strobe
  `OBT_AST(a_lat, start && !busy, ##LAT done)
  // no strobe without a matching taken word
  `OBT_AST(a_src, done, $past(start && !busy, LAT))
  // the pipeline never refuses a word
  `OBT_AST(a_busy, 1'b1, !busy)
  // reset drops the strobe
  `OBT_AST_ANY(a_rst, rst, !done)

endmodule

bind obb_overlap_test obt_checker #(
  .LAT(obt_pkg::OBT_LATENCY)
) u_obt_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
